FILE: hw/rtl/sobel_edge_binarizer_core_assert.svh
`ifndef SOBEL_EDGE_BINARIZER_CORE_ASSERT_SVH
`define SOBEL_EDGE_BINARIZER_CORE_ASSERT_SVH

// Same-cycle implication
`define SEBIN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SEBIN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sebin_pkg.sv
package sebin_pkg;

   localparam int PIX_W          = 8;
   localparam int DIM_W          = 10;
   localparam int THR_W          = 8;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 10;
   localparam int DIM_CAP        = 1023;
   localparam int MIN_DIM        = 3;
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;
   localparam int WIDTH_RST_VAL  = 512;
   localparam int HEIGHT_RST_VAL = 512;

   localparam logic [DIM_W-1:0] WIDTH_RST     = DIM_W'(WIDTH_RST_VAL);
   localparam logic [DIM_W-1:0] HEIGHT_RST    = DIM_W'(HEIGHT_RST_VAL);
   localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd25;
   localparam logic [PIX_W-1:0] EDGE_ON       = 8'hFF;
   localparam logic [PIX_W-1:0] EDGE_OFF      = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH     = 2'd0,
      REG_HEIGHT    = 2'd1,
      REG_THRESHOLD = 2'd2
   } sebin_reg_type;

   // [row][position][bit]; row 0 is the upper row, position 0 the leftmost
   typedef logic [2:0][2:0][PIX_W-1:0] sebin_win_type;

   typedef struct packed {
      logic mask_up;
      logic mask_mid;
      logic col_first;
      logic emit;
      logic last;
      logic restart;
   } sebin_tag_type;

endpackage

FILE: hw/rtl/sebin_if.sv
interface sebin_req_if import sebin_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output cmd, output pixel, input ready);
   modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface sebin_rsp_if import sebin_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] edge_value;
   logic             frame_last;

   modport source (output valid, output edge_value, output frame_last, input ready);
   modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

interface sebin_csr_if import sebin_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/sebin_csr.sv
module sebin_csr import sebin_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   localparam int W_EFF     = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP,
   localparam int H_EFF     = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP,
   localparam int WW        = $clog2(W_EFF + 1),
   localparam int HW        = $clog2(H_EFF + 1),
   localparam int CNTW      = $clog2(W_EFF * H_EFF + 1)
) (
   input  logic             clock,
   input  logic             reset,
   sebin_csr_if.sink        csr_ch,
   output logic [WW-1:0]    w_sat,
   output logic [HW-1:0]    h_sat,
   output logic [CNTW-1:0]  area,
   output logic [THR_W-1:0] threshold,
   output logic             abort
);

   localparam int W_RST_SAT = (WIDTH_RST_VAL < W_EFF) ? WIDTH_RST_VAL : W_EFF;
   localparam int H_RST_SAT = (HEIGHT_RST_VAL < H_EFF) ? HEIGHT_RST_VAL : H_EFF;
   localparam int AREA_RST  = W_RST_SAT * H_RST_SAT;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [CNTW-1:0]  area_ff, area_in;
   logic             wr;

   assign csr_ch.ready = 1'b1;
   assign wr           = csr_ch.valid && csr_ch.ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      abort     = 1'b0;
      if (wr) begin
         case (sebin_reg_type'(csr_ch.index))
            REG_WIDTH: begin
               width_in = csr_ch.data;
               abort    = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = csr_ch.data;
               abort     = 1'b1;
            end
            REG_THRESHOLD: begin
               thr_in = csr_ch.data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff < DIM_W'(MIN_DIM)) begin
         w_sat = WW'(MIN_DIM);
      end else if (width_ff > DIM_W'(W_EFF)) begin
         w_sat = WW'(W_EFF);
      end else begin
         w_sat = width_ff[WW-1:0];
      end
      if (height_ff < DIM_W'(MIN_DIM)) begin
         h_sat = HW'(MIN_DIM);
      end else if (height_ff > DIM_W'(H_EFF)) begin
         h_sat = HW'(H_EFF);
      end else begin
         h_sat = height_ff[HW-1:0];
      end
   end

   assign area_in = {{(CNTW-WW){1'b0}}, w_sat} * {{(CNTW-HW){1'b0}}, h_sat};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         thr_ff    <= THRESHOLD_RST;
         area_ff   <= CNTW'(AREA_RST);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
         area_ff   <= area_in;
      end
   end

   assign area      = area_ff;
   assign threshold = thr_ff;

endmodule

FILE: hw/rtl/sebin_seq.sv
module sebin_seq import sebin_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   localparam int W_EFF     = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP,
   localparam int H_EFF     = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP,
   localparam int WW        = $clog2(W_EFF + 1),
   localparam int HW        = $clog2(H_EFF + 1),
   localparam int CNTW      = $clog2(W_EFF * H_EFF + 1),
   localparam int AW        = $clog2(W_EFF),
   localparam int RW        = $clog2(H_EFF + 2)
) (
   input  logic             clock,
   input  logic             reset,
   sebin_req_if.sink        req_ch,
   input  logic [WW-1:0]    w_sat,
   input  logic [HW-1:0]    h_sat,
   input  logic [CNTW-1:0]  area,
   input  logic             abort,
   output logic             ld_valid,
   input  logic             ld_ready,
   output logic [AW-1:0]    ld_addr,
   output logic [PIX_W-1:0] ld_pixel,
   output sebin_tag_type    ld_tag,
   output logic             frame_start
);

   logic [AW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CNTW-1:0] given_ff, given_in;
   logic [AW:0]     col_next;
   logic            at_start;
   logic            skip;
   logic            take;
   logic            col_wrap;
   logic            in_frame;

   assign at_start = (col_ff == '0) && (row_ff == '0);
   // a flush before any pixel of the frame is swallowed
   assign skip     = req_ch.cmd && at_start;
   assign req_ch.ready = ld_ready;
   assign ld_valid = req_ch.valid && !skip;
   assign take     = ld_valid && ld_ready;

   assign col_next = {1'b0, col_ff} + 1'b1;
   assign col_wrap = col_next >= (AW+1)'(w_sat);
   assign in_frame = row_ff < RW'(h_sat);

   assign ld_addr  = col_ff;
   assign ld_pixel = (!req_ch.cmd && in_frame) ? req_ch.pixel : '0;

   always_comb begin
      ld_tag.mask_up   = (row_ff >= RW'(2)) && ((row_ff - RW'(2)) < RW'(h_sat));
      ld_tag.mask_mid  = (row_ff >= RW'(1)) && ((row_ff - RW'(1)) < RW'(h_sat));
      ld_tag.col_first = col_ff == '0;
      ld_tag.emit      = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
      ld_tag.last      = ld_tag.emit && ((given_ff + 1'b1) == area);
      ld_tag.restart   = ld_tag.last;
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      given_in = given_ff;
      if (abort) begin
         col_in   = '0;
         row_in   = '0;
         given_in = '0;
      end else if (take) begin
         if (ld_tag.restart) begin
            col_in   = '0;
            row_in   = '0;
            given_in = '0;
         end else begin
            if (col_wrap) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_next[AW-1:0];
            end
            if (ld_tag.emit) begin
               given_in = given_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         given_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         given_ff <= given_in;
      end
   end

   assign frame_start = at_start && (given_ff == '0);

endmodule

FILE: hw/rtl/sebin_line.sv
module sebin_line import sebin_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int W_EFF    = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP,
   localparam int AW       = $clog2(W_EFF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             abort,
   input  logic             ld_valid,
   output logic             ld_ready,
   input  logic [AW-1:0]    ld_addr,
   input  logic [PIX_W-1:0] ld_pixel,
   input  sebin_tag_type    ld_tag,
   output logic             win_valid,
   input  logic             win_ready,
   output sebin_win_type    win_view,
   output logic             win_last
);

   // entry: upper row in the high byte, middle row in the low byte
   logic [2*PIX_W-1:0] mem [0:W_EFF-1];
   logic [2*PIX_W-1:0] rd_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic [2*PIX_W-1:0] entry;
   logic [2*PIX_W-1:0] wr_data;
   logic               fwd_hit_ff, fwd_hit_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [AW-1:0]      addr_ff;
   logic [PIX_W-1:0]   pix_ff;
   sebin_tag_type      tag_ff;
   sebin_win_type      win_ff, win_in, win_shift, view;
   logic [2:0][PIX_W-1:0] col;
   logic               adv;
   logic               take;

   assign adv      = s1_valid_ff && (!tag_ff.emit || win_ready);
   assign ld_ready = !s1_valid_ff || adv;
   assign take     = ld_valid && ld_ready;

   assign entry   = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign col[0]  = tag_ff.mask_up ? entry[2*PIX_W-1:PIX_W] : '0;
   assign col[1]  = tag_ff.mask_mid ? entry[PIX_W-1:0] : '0;
   assign col[2]  = pix_ff;
   assign wr_data = {entry[PIX_W-1:0], pix_ff};

   assign fwd_hit_in = adv && (addr_ff == ld_addr);

   always_ff @(posedge clock) begin
      if (adv) begin
         mem[addr_ff] <= wr_data;
      end
      if (take) begin
         rd_ff <= mem[ld_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         addr_ff     <= ld_addr;
         pix_ff      <= ld_pixel;
         tag_ff      <= ld_tag;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (tag_ff.col_first) begin
            // right border of the previous row: zero column on the right
            view[i][0]      = win_ff[i][1];
            view[i][1]      = win_ff[i][2];
            view[i][2]      = '0;
            win_shift[i][0] = '0;
            win_shift[i][1] = '0;
            win_shift[i][2] = col[i];
         end else begin
            win_shift[i][0] = win_ff[i][1];
            win_shift[i][1] = win_ff[i][2];
            win_shift[i][2] = col[i];
            view[i]         = win_shift[i];
         end
      end
   end

   always_comb begin
      win_in = win_ff;
      if (abort) begin
         win_in = '0;
      end else if (adv) begin
         win_in = tag_ff.restart ? '0 : win_shift;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
      end
   end

   assign win_valid = s1_valid_ff && tag_ff.emit;
   assign win_view  = view;
   assign win_last  = tag_ff.last;

endmodule

FILE: hw/rtl/sebin_grad.sv
module sebin_grad import sebin_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [THR_W-1:0] threshold,
   input  logic             win_valid,
   output logic             win_ready,
   input  sebin_win_type    win_view,
   input  logic             win_last,
   sebin_rsp_if.source      rsp_ch
);

   localparam int SUM_W = PIX_W + 2;

   logic             s2_valid_ff, s2_valid_in;
   logic             out_valid_ff, out_valid_in;
   sebin_win_type    view_ff;
   logic             last_ff;
   logic [PIX_W-1:0] edge_ff;
   logic             olast_ff;
   logic             s2_adv;
   logic [SUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg, gx_mag, gy_mag;
   logic [SUM_W:0]   mag;
   logic [PIX_W-1:0] clipped;
   logic [PIX_W-1:0] edge_in;

   assign s2_adv    = s2_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign win_ready = !s2_valid_ff || s2_adv;

   always_comb begin
      gx_pos = SUM_W'(view_ff[0][2]) + (SUM_W'(view_ff[1][2]) << 1) + SUM_W'(view_ff[2][2]);
      gx_neg = SUM_W'(view_ff[0][0]) + (SUM_W'(view_ff[1][0]) << 1) + SUM_W'(view_ff[2][0]);
      gy_pos = SUM_W'(view_ff[0][0]) + (SUM_W'(view_ff[0][1]) << 1) + SUM_W'(view_ff[0][2]);
      gy_neg = SUM_W'(view_ff[2][0]) + (SUM_W'(view_ff[2][1]) << 1) + SUM_W'(view_ff[2][2]);
      gx_mag = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
      gy_mag = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
      mag    = {1'b0, gx_mag} + {1'b0, gy_mag};
      clipped = (|mag[SUM_W:PIX_W]) ? EDGE_ON : mag[PIX_W-1:0];
      edge_in = (clipped < threshold) ? EDGE_OFF : EDGE_ON;
   end

   always_ff @(posedge clock) begin
      if (win_valid && win_ready) begin
         view_ff <= win_view;
         last_ff <= win_last;
      end
      if (s2_adv) begin
         edge_ff  <= edge_in;
         olast_ff <= last_ff;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (win_valid && win_ready) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s2_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.edge_value = edge_ff;
   assign rsp_ch.frame_last = olast_ff;

endmodule

FILE: hw/rtl/sobel_edge_binarizer_core.sv
// Channel   Dir  Payload                          Accepted when
// req_ch    in   cmd, pixel                       valid && ready
// rsp_ch    out  edge_value, frame_last           valid && ready
// csr_ch    in   index, data                      valid && ready (ready always high)
//
// One request per clock unless rsp_ch stalls; one line-store read and write per cycle.
// rsp_ch.valid is registered, behind the line stage and the gradient input stage.
// Reset: 512 x 512, threshold 25, counters and window cleared; no line-store clearing
// pass, as line-store data from rows not yet written is masked to zero.
// A stalled rsp_ch backs up through the gradient and window stages to req_ch.ready.

`include "sobel_edge_binarizer_core_assert.svh"

module sobel_edge_binarizer_core import sebin_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sebin_req_if.sink   req_ch,
   sebin_rsp_if.source rsp_ch,
   sebin_csr_if.sink   csr_ch
);

   localparam int W_EFF = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
   localparam int H_EFF = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;
   localparam int WW    = $clog2(W_EFF + 1);
   localparam int HW    = $clog2(H_EFF + 1);
   localparam int CNTW  = $clog2(W_EFF * H_EFF + 1);
   localparam int AW    = $clog2(W_EFF);

   logic [WW-1:0]    w_sat;
   logic [HW-1:0]    h_sat;
   logic [CNTW-1:0]  area;
   logic [THR_W-1:0] threshold;
   logic             abort;
   logic             ld_valid;
   logic             ld_ready;
   logic [AW-1:0]    ld_addr;
   logic [PIX_W-1:0] ld_pixel;
   sebin_tag_type    ld_tag;
   logic             frame_start;
   logic             win_valid;
   logic             win_ready;
   sebin_win_type    win_view;
   logic             win_last;

   sebin_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .w_sat     (w_sat),
      .h_sat     (h_sat),
      .area      (area),
      .threshold (threshold),
      .abort     (abort)
   );

   sebin_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .w_sat       (w_sat),
      .h_sat       (h_sat),
      .area        (area),
      .abort       (abort),
      .ld_valid    (ld_valid),
      .ld_ready    (ld_ready),
      .ld_addr     (ld_addr),
      .ld_pixel    (ld_pixel),
      .ld_tag      (ld_tag),
      .frame_start (frame_start)
   );

   sebin_line #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .abort     (abort),
      .ld_valid  (ld_valid),
      .ld_ready  (ld_ready),
      .ld_addr   (ld_addr),
      .ld_pixel  (ld_pixel),
      .ld_tag    (ld_tag),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .win_view  (win_view),
      .win_last  (win_last)
   );

   sebin_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .win_view  (win_view),
      .win_last  (win_last),
      .rsp_ch    (rsp_ch)
   );

   `SEBIN_ASSERT_IMPL(a_edge_binary, clock, reset, rsp_ch.valid, rsp_ch.edge_value == EDGE_ON || rsp_ch.edge_value == EDGE_OFF, "edge result neither 0 nor 255")
   `SEBIN_ASSERT_NEXT(a_restart_clears, clock, reset, ld_valid && ld_ready && ld_tag.restart, frame_start, "frame end did not rewind the sequencer")
   `SEBIN_ASSERT_IMPL(a_last_at_start, clock, reset, win_valid && win_last, frame_start, "last window pending while sequencer is mid-frame")

endmodule
